### hw/rtl/rrol_pkg.sv
// ----------------------------------------------------------------------------
// rrol_pkg: shared types and constants of the record ring lookup unit
// Holds the command codes, the sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
package rrol_pkg;

	// Fixed widths of the stream fields.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned LENGTH_W = 20;
	localparam int unsigned OFFSET_W = 24;
	localparam int unsigned ENTRY_W  = 4;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned POS_W    = 24;
	localparam int unsigned TOTAL_W  = 24;

	// Beat widths; the data beats are rounded up to whole bytes.
	localparam int unsigned S_TDATA_W = 104;
	localparam int unsigned M_TDATA_W = 136;
	localparam int unsigned M_TUSER_W = 2;

	// Command codes carried in s_tuser.
	localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEEK = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/record_ring_with_offset_lookup_unit.sv
// ----------------------------------------------------------------------------
// record_ring_with_offset_lookup_unit: ring of records with offset lookup
// Stores handle and length records in a ring, finds the record holding a
// global character offset and turns a record number into a byte position.
// ----------------------------------------------------------------------------
// Usage.
// Commands arrive on the slave stream (s_tvalid/s_tready/s_tdata/s_tuser);
// s_tuser carries the command: add, find or seek. Every command beat gives
// exactly one result beat on the master stream (m_tvalid/m_tready/m_tdata/
// m_tuser), in command order. m_tuser carries status and the eviction flag.
// The unit works on one command at a time. An add reads the slot, writes
// it and hands the result over. A find walks at most RING_DEPTH records;
// a seek checks the target record and then walks entry_number records,
// or none when the target record is rejected; an undefined command goes
// straight to the hand-over. The walks read one stored length per cycle
// from the record memory, which has a single registered read port, so
// RING_DEPTH sets the worst case per command.
// A new command is accepted while the previous result still waits in the
// output register; only the hand-over of the next result waits for it.
// Reset clears the ring pointers, the byte total and the per-slot valid
// bits, so every slot reads as an empty record right after reset. A
// stalled receiver holds the result beat steady until m_tready rises.
// ----------------------------------------------------------------------------
module record_ring_with_offset_lookup_unit
	import rrol_pkg::*;
#(
	parameter int unsigned RING_DEPTH  = 16,
	parameter int unsigned LENGTH_BITS = 20,
	parameter int unsigned HANDLE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Slave side: command beats.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata, low bit up: record_handle[31:0], record_length[51:32],
	// text_offset[75:52], entry_number[79:76], byte_offset[99:80], zero pad.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: command[1:0].
	input  logic [CMD_W-1:0]     s_tuser,
	// Master side: result beats.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata, low bit up: evicted_handle[31:0], found_handle[63:32],
	// found_slot[67:64], byte_in_record[87:68], position[111:88],
	// total_bytes[135:112].
	output logic [M_TDATA_W-1:0] m_tdata,
	// m_tuser, low bit up: status[0], evicted_valid[1].
	output logic [M_TUSER_W-1:0] m_tuser
);

	// Slot index, count and arithmetic widths follow the ring depth. Stored
	// handles and lengths never hold more bits than the input fields carry.
	localparam int unsigned SW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
	localparam int unsigned SUMW = ((SW > ENTRY_W) ? SW : ENTRY_W) + 1;
	localparam int unsigned HW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int unsigned LW   = (LENGTH_BITS < LENGTH_W) ? LENGTH_BITS : LENGTH_W;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		if (s == SW'(RING_DEPTH - 1)) begin
			return '0;
		end
		return s + 1'b1;
	endfunction

	// Input field unpacking.
	logic [CMD_W-1:0]    in_cmd;
	logic [HW-1:0]       in_handle;
	logic [LW-1:0]       in_length;
	logic [OFFSET_W-1:0] in_text_offset;
	logic [ENTRY_W-1:0]  in_entry;
	logic [LENGTH_W-1:0] in_byte_offset;

	assign in_cmd         = s_tuser;
	assign in_handle      = HW'(s_tdata[31:0]);
	assign in_length      = LW'(s_tdata[51:32]);
	assign in_text_offset = s_tdata[75:52];
	assign in_entry       = s_tdata[79:76];
	assign in_byte_offset = s_tdata[99:80];

	// Sequencer and ring state.
	state_t state_q, state_d;

	logic [SW-1:0]         write_slot_q;
	logic [SW-1:0]         read_slot_q;
	logic                  ring_full_q;
	logic [TOTAL_W-1:0]    byte_total_q;
	logic [RING_DEPTH-1:0] slot_vld_q;

	// The record memories: one write port, one registered read port.
	logic [HW-1:0] handle_mem [RING_DEPTH];
	logic [LW-1:0] length_mem [RING_DEPTH];
	logic [HW-1:0] handle_rd_s1;
	logic [LW-1:0] length_rd_s1;
	logic          rd_vld_s1;
	logic [SW-1:0] rd_addr;
	logic          mem_we;
	logic [HW-1:0] handle_rd;
	logic [LW-1:0] length_rd;

	// Command registers and the walk.
	logic [CMD_W-1:0]    cmd_q;
	logic [HW-1:0]       handle_in_q;
	logic [LW-1:0]       length_in_q;
	logic [LENGTH_W-1:0] byte_offset_q;
	logic [OFFSET_W-1:0] work_q;
	logic [SW-1:0]       walk_slot_q;
	logic [CW-1:0]       walk_cnt_q;

	// Result under construction.
	logic                res_status_q;
	logic                res_evicted_q;
	logic [HW-1:0]       res_evicted_handle_q;
	logic [HW-1:0]       res_found_handle_q;
	logic [SW-1:0]       res_slot_q;
	logic [LENGTH_W-1:0] res_byte_q;
	logic [POS_W-1:0]    res_position_q;

	// Output register.
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	// Derived control.
	logic                s_accept;
	logic                out_free;
	logic                out_load;
	logic [CW-1:0]       stored_cnt;
	logic [SUMW-1:0]     seek_sum;
	logic                seek_num_bad;
	logic [SW-1:0]       seek_idx;
	logic                find_hit;
	logic                seek_bad;
	logic [OFFSET_W-1:0] walk_sum;
	logic [SW-1:0]       evict_read_slot;
	logic [SW-1:0]       add_next_slot;

	// A slot never written reads as an empty record.
	assign handle_rd = rd_vld_s1 ? handle_rd_s1 : '0;
	assign length_rd = rd_vld_s1 ? length_rd_s1 : '0;

	always_comb begin
		if (ring_full_q) begin
			stored_cnt = CW'(RING_DEPTH);
		end else if (write_slot_q >= read_slot_q) begin
			stored_cnt = CW'(write_slot_q) - CW'(read_slot_q);
		end else begin
			// The write slot has wrapped past the end of the ring.
			stored_cnt = CW'(write_slot_q) + CW'(RING_DEPTH) - CW'(read_slot_q);
		end
	end

	// Physical slot of a seek target: read slot plus the record number,
	// wrapped once, since both are below the depth when the number is legal.
	assign seek_sum     = SUMW'(read_slot_q) + SUMW'(in_entry);
	assign seek_num_bad = SUMW'(in_entry) >= SUMW'(RING_DEPTH);
	assign seek_idx     = (seek_sum >= SUMW'(RING_DEPTH)) ?
		SW'(seek_sum - SUMW'(RING_DEPTH)) : SW'(seek_sum);

	assign find_hit = work_q < OFFSET_W'(length_rd);
	assign seek_bad = (handle_rd == '0) || (length_rd == '0) ||
		(byte_offset_q >= LENGTH_W'(length_rd));
	assign walk_sum = work_q + OFFSET_W'(length_rd);

	assign evict_read_slot = ring_full_q ? slot_next(read_slot_q) : read_slot_q;
	assign add_next_slot   = slot_next(write_slot_q);

	assign out_free = !m_tvalid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_cmd)
						CMD_ADD:  state_d = ST_ADD;
						CMD_FIND: state_d = (stored_cnt == '0) ? ST_DONE : ST_WALK;
						CMD_SEEK: state_d = seek_num_bad ? ST_DONE : ST_CHECK;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD: state_d = ST_DONE;
			ST_CHECK: begin
				if (seek_bad || (walk_cnt_q == '0)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if ((walk_cnt_q == CW'(1)) || ((cmd_q == CMD_FIND) && find_hit)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		rd_addr  = slot_next(walk_slot_q);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_cmd == CMD_ADD) begin
					rd_addr = write_slot_q;
				end else if (in_cmd == CMD_SEEK) begin
					rd_addr = seek_idx;
				end else begin
					rd_addr = read_slot_q;
				end
			end
			ST_ADD:   mem_we = 1'b1;
			ST_CHECK: rd_addr = read_slot_q;
			ST_WALK:  rd_addr = slot_next(walk_slot_q);
			ST_DONE:  out_load = out_free;
			default:  s_tready = 1'b0;
		endcase
	end

	assign s_accept = s_tvalid && s_tready;

	// Record memories.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			handle_mem[write_slot_q] <= handle_in_q;
			length_mem[write_slot_q] <= length_in_q;
		end
		handle_rd_s1 <= handle_mem[rd_addr];
		length_rd_s1 <= length_mem[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			ring_full_q  <= 1'b0;
			byte_total_q <= '0;
			slot_vld_q   <= '0;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= slot_vld_q[rd_addr];
			if (mem_we) begin
				// Replace the old length in the total, advance the ring.
				slot_vld_q[write_slot_q] <= 1'b1;
				byte_total_q <= byte_total_q + TOTAL_W'(length_in_q) - TOTAL_W'(length_rd);
				read_slot_q  <= evict_read_slot;
				write_slot_q <= add_next_slot;
				ring_full_q  <= (add_next_slot == evict_read_slot);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command, walk and result datapath.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q                <= in_cmd;
			handle_in_q          <= in_handle;
			length_in_q          <= in_length;
			byte_offset_q        <= in_byte_offset;
			work_q               <= in_text_offset;
			walk_slot_q          <= read_slot_q;
			walk_cnt_q           <= (in_cmd == CMD_FIND) ? stored_cnt : CW'(in_entry);
			res_status_q         <= (in_cmd != CMD_ADD);
			res_evicted_q        <= 1'b0;
			res_evicted_handle_q <= '0;
			res_found_handle_q   <= '0;
			res_slot_q           <= '0;
			res_byte_q           <= '0;
			res_position_q       <= '0;
		end
		if (state_q == ST_ADD) begin
			res_evicted_q        <= ring_full_q;
			res_evicted_handle_q <= ring_full_q ? handle_rd : '0;
		end
		if (state_q == ST_CHECK) begin
			// The walk sum starts from the byte offset.
			work_q <= OFFSET_W'(byte_offset_q);
			if (!seek_bad && (walk_cnt_q == '0)) begin
				res_status_q   <= 1'b0;
				res_position_q <= POS_W'(byte_offset_q);
			end
		end
		if (state_q == ST_WALK) begin
			walk_slot_q <= slot_next(walk_slot_q);
			walk_cnt_q  <= walk_cnt_q - 1'b1;
			if (cmd_q == CMD_FIND) begin
				if (find_hit) begin
					res_status_q       <= 1'b0;
					res_found_handle_q <= handle_rd;
					res_slot_q         <= walk_slot_q;
					res_byte_q         <= work_q[LENGTH_W-1:0];
				end else begin
					work_q <= work_q - OFFSET_W'(length_rd);
				end
			end else begin
				work_q <= walk_sum;
				if (walk_cnt_q == CW'(1)) begin
					res_status_q   <= 1'b0;
					res_position_q <= walk_sum;
				end
			end
		end
		if (out_load) begin
			m_tdata_q <= {byte_total_q, res_position_q, res_byte_q, SLOT_W'(res_slot_q),
				HANDLE_W'(res_found_handle_q), HANDLE_W'(res_evicted_handle_q)};
			m_tuser_q <= {res_evicted_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	// A full ring has its write slot caught up with its read slot.
	a_full_slots: assert property (@(posedge clk) disable iff (!arst_n)
		ring_full_q |-> (write_slot_q == read_slot_q))
		else $error("ring full with write and read slots apart");

	// The write slot stays inside the depth, also for depths that are not powers of two.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(write_slot_q < SW'(RING_DEPTH - 1)) || (write_slot_q == SW'(RING_DEPTH - 1)) ||
		(read_slot_q == '1))
		else $error("write slot beyond ring depth");

	// A walk never runs with its record count exhausted.
	a_walk_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_cnt_q != '0))
		else $error("walk with no records left");

	// A result is loaded only into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending beat");

	// An accepted command leaves the idle state.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q != ST_IDLE))
		else $error("command accepted but sequencer stayed idle");
`endif

endmodule

### dv/record_ring_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// record_ring_scoreboard_pkg: predictor and scoreboard for the record ring
// Mirrors the ring of handle and length records, predicts the reply to every
// accepted command beat and checks reply beats against them in order.
// ----------------------------------------------------------------------------
package record_ring_scoreboard_pkg;
	import rrol_pkg::*;

	localparam int unsigned RING_SLOTS = 16;

	// s_tuser can carry a fourth code that the unit must reject.
	localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

	// Reply layout, {m_tuser, m_tdata} from the top bit down.
	typedef struct packed {
		logic                evicted_valid;
		logic                status;
		logic [TOTAL_W-1:0]  total_bytes;
		logic [POS_W-1:0]    position;
		logic [LENGTH_W-1:0] byte_in_record;
		logic [SLOT_W-1:0]   found_slot;
		logic [HANDLE_W-1:0] found_handle;
		logic [HANDLE_W-1:0] evicted_handle;
	} ring_reply_t;

	class record_ring_scoreboard;
		logic [HANDLE_W-1:0] handle_store[RING_SLOTS];
		logic [LENGTH_W-1:0] length_store[RING_SLOTS];
		logic [SLOT_W-1:0]   write_slot;
		logic [SLOT_W-1:0]   read_slot;
		logic                ring_full;
		logic [TOTAL_W-1:0]  byte_total;
		ring_reply_t         awaited_replies[$];
		int                  mismatch_count;
		int                  reply_count;

		function new();
			foreach (handle_store[i]) begin
				handle_store[i] = '0;
				length_store[i] = '0;
			end
			write_slot     = '0;
			read_slot      = '0;
			ring_full      = 1'b0;
			byte_total     = '0;
			mismatch_count = 0;
			reply_count    = 0;
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		// Works out the reply of one command and advances the ring copy.
		function ring_reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
				logic [LENGTH_W-1:0] len, logic [OFFSET_W-1:0] text_offset,
				logic [ENTRY_W-1:0] entry, logic [LENGTH_W-1:0] byte_offset);
			ring_reply_t         reply;
			logic [SLOT_W-1:0]   slot;
			logic [OFFSET_W-1:0] remaining;
			logic [POS_W-1:0]    sum;
			int                  count;
			reply = '0;
			case (cmd)
				CMD_ADD: begin
					slot = write_slot;
					if (ring_full) begin
						reply.evicted_valid  = 1'b1;
						reply.evicted_handle = handle_store[slot];
						read_slot++;
					end
					byte_total         = byte_total + TOTAL_W'(len) - TOTAL_W'(length_store[slot]);
					handle_store[slot] = handle;
					length_store[slot] = len;
					write_slot         = slot + 1'b1;
					ring_full          = (write_slot == read_slot);
				end
				CMD_FIND: begin
					count        = ring_full ? RING_SLOTS : int'(SLOT_W'(write_slot - read_slot));
					slot         = read_slot;
					remaining    = text_offset;
					reply.status = 1'b1;
					for (int i = 0; i < count; i++) begin
						if (remaining < OFFSET_W'(length_store[slot])) begin
							reply.status         = 1'b0;
							reply.found_handle   = handle_store[slot];
							reply.found_slot     = slot;
							reply.byte_in_record = remaining[LENGTH_W-1:0];
							break;
						end
						remaining = remaining - OFFSET_W'(length_store[slot]);
						slot++;
					end
				end
				CMD_SEEK: begin
					slot = read_slot + entry;
					if (handle_store[slot] == '0 || length_store[slot] == '0 ||
							byte_offset >= length_store[slot]) begin
						reply.status = 1'b1;
					end else begin
						sum  = '0;
						slot = read_slot;
						for (int i = 0; i < int'(entry); i++) begin
							sum = sum + POS_W'(length_store[slot]);
							slot++;
						end
						reply.position = sum + POS_W'(byte_offset);
					end
				end
				default: begin
					reply.status = 1'b1;
				end
			endcase
			reply.total_bytes = byte_total;
			return reply;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [S_TDATA_W-1:0] beat);
			awaited_replies.push_back(predict_reply(cmd, beat[31:0], beat[51:32], beat[75:52],
				beat[79:76], beat[99:80]));
		endfunction

		function void check_reply(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
			ring_reply_t seen;
			ring_reply_t wanted;
			seen = ring_reply_t'({tuser, tdata});
			reply_count++;
			if (awaited_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("reply %0d arrived with no command pending: %p", reply_count, seen);
				return;
			end
			wanted = awaited_replies.pop_front();
			if (seen !== wanted) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("reply %0d mismatch\n  expected %p\n  actual   %p",
						reply_count, wanted, seen);
			end
		endfunction
	endclass

endpackage

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level test of record_ring_with_offset_lookup_unit
// Drives add, find, seek and undefined command beats with random gaps and
// receiver stalls, predicts every reply and checks each reply beat in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrol_pkg::*;
	import record_ring_scoreboard_pkg::*;

	// The limit covers the worst case per beat (the unit's own work plus a
	// sender gap and a receiver stall) over all 550 beats with wide margin.
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_BEATS = 535;
	localparam int QUIET_BEATS  = 60;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [CMD_W-1:0]     s_tuser  = CMD_ADD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	record_ring_scoreboard sb = new();

	// When set, neither side idles any more.
	bit quiet = 1'b0;
	int cycle_count = 0;

	// Receiver stall bursts: each burst is either all ready or all stalled.
	int stall_left = 0;
	bit stalling   = 1'b0;

	record_ring_with_offset_lookup_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// m_tready is sampled before this edge updates it, so the value read here
	// is the one the unit saw at the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_reply(m_tuser, m_tdata);
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stalling   = ($urandom_range(0, 2) == 0);
			stall_left = $urandom_range(1, 16);
		end
		stall_left--;
		m_tready <= quiet || !stalling;
	end

	// Presents one command beat, waits for the handshake and hands the beat
	// to the scoreboard. valid stays high into the next call unless the
	// sender takes a gap, so it never gets two assignments in one step.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
			input logic [LENGTH_W-1:0] len, input logic [OFFSET_W-1:0] text_offset,
			input logic [ENTRY_W-1:0] entry, input logic [LENGTH_W-1:0] byte_offset);
		logic [S_TDATA_W-1:0] beat;
		beat     = {4'b0, byte_offset, entry, text_offset, len, handle};
		s_tuser  <= cmd;
		s_tdata  <= beat;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_command(cmd, beat);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// One random command. Most finds aim inside the stored bytes and most
	// seeks aim inside the chosen record, so both reach their hit paths; the
	// rest probe the misses with the boundary offset or fully random fields.
	task automatic send_random_command();
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] len;
		logic [OFFSET_W-1:0] text_offset;
		logic [ENTRY_W-1:0]  entry;
		logic [LENGTH_W-1:0] byte_offset;
		logic [LENGTH_W-1:0] target_len;
		int                  pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			cmd = CMD_ADD;
		else if (pick < 70)
			cmd = CMD_FIND;
		else if (pick < 97)
			cmd = CMD_SEEK;
		else
			cmd = CMD_UNDEFINED;

		handle = $urandom;
		if ($urandom_range(0, 15) == 0)
			handle = '0;

		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = '0;
		else if (pick == 1)
			len = LENGTH_W'($urandom);
		else
			len = LENGTH_W'($urandom_range(1, 4095));

		if ($urandom_range(0, 9) < 8)
			text_offset = OFFSET_W'($urandom_range(0, int'(sb.byte_total)));
		else
			text_offset = OFFSET_W'($urandom);

		entry      = ENTRY_W'($urandom);
		target_len = sb.length_store[SLOT_W'(sb.read_slot + entry)];
		pick       = $urandom_range(0, 9);
		if (target_len != '0 && pick < 8)
			byte_offset = LENGTH_W'($urandom_range(0, int'(target_len) - 1));
		else if (pick == 8)
			byte_offset = target_len;
		else
			byte_offset = LENGTH_W'($urandom);

		send_command(cmd, handle, len, text_offset, entry, byte_offset);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. On an empty ring both lookups must miss, and an
		// undefined code must be rejected without touching the ring.
		send_command(CMD_FIND, '0, '0, '0, '0, '0);
		send_command(CMD_SEEK, '0, '0, '0, '0, '0);
		send_command(CMD_UNDEFINED, '1, '1, '1, '1, '1);
		// A record with handle zero is stored, found, but refused by seek.
		send_command(CMD_ADD, '0, 20'd100, '0, '0, '0);
		send_command(CMD_SEEK, '0, '0, '0, 4'd0, 20'd5);
		send_command(CMD_FIND, '0, '0, 24'd50, '0, '0);
		// Largest handle and length, then an empty-length record.
		send_command(CMD_ADD, '1, '1, '0, '0, '0);
		send_command(CMD_ADD, 32'h1234_5678, '0, '0, '0, '0);
		send_command(CMD_SEEK, '0, '0, '0, 4'd2, '0);
		// Seek offset equal to the record length fails, one below succeeds.
		send_command(CMD_SEEK, '0, '0, '0, 4'd1, 20'hF_FFFF);
		send_command(CMD_SEEK, '0, '0, '0, 4'd1, 20'hF_FFFE);
		send_command(CMD_FIND, '0, '0, 24'd100, '0, '0);
		// Offsets just past and far past the stored data.
		send_command(CMD_FIND, '0, '0, 24'd1048675, '0, '0);
		send_command(CMD_FIND, '0, '0, '1, '0, '0);
		// Highest record number points at a never-written slot.
		send_command(CMD_SEEK, '0, '0, '0, 4'd15, '0);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// Halfway through, hold off until the unit has drained.
			if (n == RANDOM_BEATS / 2) begin
				s_tvalid <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
			end
			if (n == RANDOM_BEATS - QUIET_BEATS)
				quiet = 1'b1;
			send_random_command();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// Let any stray reply beat show up before judging.
		repeat (40) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### record_ring_with_offset_lookup_unit.f
hw/rtl/rrol_pkg.sv
hw/rtl/record_ring_with_offset_lookup_unit.sv
dv/record_ring_scoreboard_pkg.sv
dv/testbench.sv
